### sv/nfcd_pkg.sv
// Shared types and constants for the NFC host frame deframer.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nfcd_pkg;

	localparam int unsigned HUNT_LIMIT_DEF = 61;
	localparam logic [7:0] CAPACITY_RST = 8'hFF;
	localparam logic [7:0] CMD_RST = 8'h00;

	localparam logic [7:0] BYTE_ZERO = 8'h00;
	localparam logic [7:0] BYTE_START = 8'hFF;
	localparam logic [7:0] BYTE_TFI = 8'hD5;
	localparam logic [7:0] LEN_OVERHEAD = 8'd2;

	typedef enum logic [1:0] {
		CFG_EXP_CMD = 2'd0,
		CFG_CAPACITY = 2'd1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_INVALID = 2'd1,
		ST_NOSPACE = 2'd2
	} status_t;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// classified byte handed from front to back
	typedef struct packed {
		logic [7:0] rx_byte;
		logic restart;
		logic is_zero;
		logic is_start;
		logic is_tfi;
		logic is_resp;
	} item_t;

	typedef struct packed {
		logic kind;
		logic [7:0] data_byte;
		logic [1:0] status;
		logic [7:0] payload_length;
		logic last;
	} result_t;

endpackage

`default_nettype wire

### sv/nfcd_front.sv
// Front end: input handshake and byte classification.
// Depends on nfcd_pkg; pushes classified items into nfcd_queue.
`timescale 1ns / 1ps
`default_nettype none

module nfcd_front
	import nfcd_pkg::*;
(
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [7:0] rx_byte,
	input wire logic restart,
	input wire logic [7:0] expected_command,
	input wire logic q_full,
	output logic q_push,
	output item_t q_item
);

	logic [7:0] resp_code;

	assign resp_code = expected_command + 8'd1;
	assign in_ready = !q_full;
	assign q_push = in_valid && !q_full;

	always_comb begin
		q_item.rx_byte = rx_byte;
		q_item.restart = restart;
		q_item.is_zero = (rx_byte == BYTE_ZERO);
		q_item.is_start = (rx_byte == BYTE_START);
		q_item.is_tfi = (rx_byte == BYTE_TFI);
		q_item.is_resp = (rx_byte == resp_code);
	end

endmodule

`default_nettype wire

### sv/nfcd_queue.sv
// Two-entry queue of classified items between front and back.
// Depends on nfcd_pkg for item_t.
`timescale 1ns / 1ps
`default_nettype none

module nfcd_queue
	import nfcd_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire item_t push_item,
	input wire logic pop,
	output logic full,
	output logic empty,
	output item_t head
);

	item_t mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;

	assign full = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### sv/nfcd_back.sv
// Back end: frame state machine, checksums and the output register.
// Depends on nfcd_pkg; pops classified items from nfcd_queue.
`timescale 1ns / 1ps
`default_nettype none

module nfcd_back
	import nfcd_pkg::*;
#(
	parameter int unsigned HUNT_LIMIT = HUNT_LIMIT_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [7:0] expected_command,
	input wire logic [7:0] capacity,
	input wire logic q_empty,
	input wire item_t q_head,
	output logic q_pop,
	output logic out_valid,
	input wire logic out_ready,
	output result_t out_res
);

	localparam logic [7:0] HuntLim = 8'(HUNT_LIMIT);

	typedef enum logic [7:0] {
		PH_HUNT = 8'b0000_0001,
		PH_LEN = 8'b0000_0010,
		PH_LCS = 8'b0000_0100,
		PH_TFI = 8'b0000_1000,
		PH_CMD = 8'b0001_0000,
		PH_DATA = 8'b0010_0000,
		PH_DCS = 8'b0100_0000,
		PH_DONE = 8'b1000_0000
	} phase_t;

	phase_t phase_q, phase_cur, phase_d;
	logic [1:0] match_q, match_cur, match_d;
	logic [7:0] hunt_q, hunt_cur, hunt_d;
	logic [7:0] flen_q, flen_cur, flen_d;
	logic [7:0] left_q, left_cur, left_d;
	logic [7:0] sum_q, sum_cur, sum_d;

	logic out_valid_q;
	result_t res_q;
	logic emit;
	result_t res_d;
	logic [7:0] byte_in;
	logic [7:0] plen;
	logic [7:0] data_len;

	assign q_pop = !q_empty && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_res = res_q;
	assign byte_in = q_head.rx_byte;
	assign plen = flen_cur - LEN_OVERHEAD;
	assign data_len = flen_cur - LEN_OVERHEAD;

	always_comb begin
		// restart wipes frame state before this byte is handled
		if (q_head.restart) begin
			phase_cur = PH_HUNT;
			match_cur = 2'd0;
			hunt_cur = 8'd0;
			flen_cur = 8'd0;
			left_cur = 8'd0;
			sum_cur = 8'd0;
		end else begin
			phase_cur = phase_q;
			match_cur = match_q;
			hunt_cur = hunt_q;
			flen_cur = flen_q;
			left_cur = left_q;
			sum_cur = sum_q;
		end

		phase_d = phase_cur;
		match_d = match_cur;
		hunt_d = hunt_cur;
		flen_d = flen_cur;
		left_d = left_cur;
		sum_d = sum_cur;
		emit = 1'b0;
		res_d.kind = KIND_STATUS;
		res_d.data_byte = 8'd0;
		res_d.status = ST_INVALID;
		res_d.payload_length = 8'd0;
		res_d.last = 1'b1;

		unique case (phase_cur)
			PH_HUNT: begin
				if (hunt_cur != 8'hFF) begin
					hunt_d = hunt_cur + 8'd1;
				end
				if (q_head.is_zero) begin
					match_d = (match_cur == 2'd2) ? 2'd2 : match_cur + 2'd1;
				end else if (q_head.is_start && match_cur == 2'd2) begin
					match_d = 2'd0;
					phase_d = PH_LEN;
				end else begin
					match_d = 2'd0;
				end
				// give up once the hunt limit is reached without a start code
				if (phase_d == PH_HUNT && hunt_d >= HuntLim) begin
					emit = 1'b1;
					phase_d = PH_DONE;
				end
			end
			PH_LEN: begin
				flen_d = byte_in;
				phase_d = PH_LCS;
			end
			PH_LCS: begin
				if ((flen_cur + byte_in) != 8'd0 || flen_cur < LEN_OVERHEAD) begin
					emit = 1'b1;
					phase_d = PH_DONE;
				end else begin
					phase_d = PH_TFI;
				end
			end
			PH_TFI: begin
				if (!q_head.is_tfi) begin
					emit = 1'b1;
					phase_d = PH_DONE;
				end else begin
					phase_d = PH_CMD;
				end
			end
			PH_CMD: begin
				if (!q_head.is_resp) begin
					emit = 1'b1;
					phase_d = PH_DONE;
				end else begin
					left_d = data_len;
					if (data_len > capacity) begin
						emit = 1'b1;
						res_d.status = ST_NOSPACE;
						phase_d = PH_DONE;
					end else begin
						sum_d = BYTE_TFI + expected_command + 8'd1;
						phase_d = (data_len == 8'd0) ? PH_DCS : PH_DATA;
					end
				end
			end
			PH_DATA: begin
				sum_d = sum_cur + byte_in;
				left_d = left_cur - 8'd1;
				if (left_cur == 8'd1) begin
					phase_d = PH_DCS;
				end
				emit = 1'b1;
				res_d.kind = KIND_DATA;
				res_d.data_byte = byte_in;
				res_d.status = ST_OK;
				res_d.last = 1'b0;
			end
			PH_DCS: begin
				emit = 1'b1;
				phase_d = PH_DONE;
				if ((sum_cur + byte_in) == 8'd0) begin
					res_d.status = ST_OK;
					res_d.payload_length = plen;
				end
			end
			PH_DONE: begin
				phase_d = PH_DONE;
			end
			default: begin
				phase_d = PH_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			match_q <= 2'd0;
			hunt_q <= 8'd0;
			flen_q <= 8'd0;
			left_q <= 8'd0;
			sum_q <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				phase_q <= phase_d;
				match_q <= match_d;
				hunt_q <= hunt_d;
				flen_q <= flen_d;
				left_q <= left_d;
				sum_q <= sum_d;
			end
			// hold the result until the receiver takes it
			if (q_pop) begin
				out_valid_q <= emit;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && emit) begin
			res_q <= res_d;
		end
	end

endmodule

`default_nettype wire

### sv/nfcd_core_top.sv
// Top level of the NFC host frame deframer: config registers and wiring.
// Depends on nfcd_pkg, nfcd_front, nfcd_queue and nfcd_back.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one received byte per transfer,
//   with restart set on the byte that begins a new frame hunt.
//   Output channel (out_valid/out_ready) gives payload bytes (kind 0) as they
//   arrive and one final status transfer (kind 1, last 1) per frame.
//   Config channel (cfg_valid/cfg_ready) is always ready; index 0 sets the
//   expected command, index 1 the payload capacity. Write only while idle.
// Timing:
//   One byte per cycle sustained while out_ready stays high. A byte is
//   classified at acceptance, held in a two-entry queue and run through the
//   frame state machine into the output register, from which its result
//   transfers.
// Reset:
//   Clears the queue, the output valid flag and the frame state; the expected
//   command resets to 00 and the capacity to FF.
// Stall:
//   While out_ready is low the output register holds, the state machine stops
//   popping once a result waits there and the queue fills; in_ready drops
//   once both entries are taken.
`timescale 1ns / 1ps
`default_nettype none

module nfc_host_frame_deframer_core
	import nfcd_pkg::*;
#(
	parameter int unsigned HUNT_LIMIT = HUNT_LIMIT_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [7:0] rx_byte,
	input wire logic restart,
	output logic out_valid,
	input wire logic out_ready,
	output logic kind,
	output logic [7:0] data_byte,
	output logic [1:0] status,
	output logic [7:0] payload_length,
	output logic last,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [1:0] cfg_index,
	input wire logic [7:0] cfg_data
);

	logic [7:0] exp_cmd_q;
	logic [7:0] capacity_q;
	logic q_full;
	logic q_empty;
	logic q_push;
	logic q_pop;
	item_t q_in;
	item_t q_head;
	result_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_cmd_q <= CMD_RST;
			capacity_q <= CAPACITY_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_EXP_CMD: exp_cmd_q <= cfg_data;
				CFG_CAPACITY: capacity_q <= cfg_data;
				default: ;
			endcase
		end
	end

	nfcd_front u_front (
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.restart(restart),
		.expected_command(exp_cmd_q),
		.q_full(q_full),
		.q_push(q_push),
		.q_item(q_in)
	);

	nfcd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_item(q_in),
		.pop(q_pop),
		.full(q_full),
		.empty(q_empty),
		.head(q_head)
	);

	nfcd_back #(
		.HUNT_LIMIT(HUNT_LIMIT)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.expected_command(exp_cmd_q),
		.capacity(capacity_q),
		.q_empty(q_empty),
		.q_head(q_head),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_res(res)
	);

	assign kind = res.kind;
	assign data_byte = res.data_byte;
	assign status = res.status;
	assign payload_length = res.payload_length;
	assign last = res.last;

endmodule

`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for nfc_host_frame_deframer_core: builds response frames,
// predicts the payload and status transfers, and checks them in order.
// Depends on nfcd_pkg and the deframer RTL.
`timescale 1ns / 1ps

module testbench;
	import nfcd_pkg::*;

	localparam int unsigned HUNT_LIMIT = HUNT_LIMIT_DEF;

	typedef enum int {
		F_NONE,
		F_LCS,
		F_SHORT_LEN,
		F_TFI,
		F_CMD,
		F_DCS,
		F_CUT
	} frame_flaw_t;

	// Tracks the deframer state and holds the transfers it owes, oldest first.
	class deframe_checker;
		typedef enum int {
			P_HUNT, P_LEN, P_LCS, P_TFI, P_CMD, P_DATA, P_DCS, P_DONE
		} frame_phase_t;

		logic [7:0] exp_cmd;
		logic [7:0] capacity;
		frame_phase_t phase;
		logic [1:0] start_match;
		logic [7:0] hunt_count;
		logic [7:0] frame_length;
		logic [7:0] bytes_left;
		logic [7:0] running_sum;
		result_t due_results[$];
		int errors;

		function new();
			exp_cmd = CMD_RST;
			capacity = CAPACITY_RST;
			errors = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			phase = P_HUNT;
			start_match = 2'd0;
			hunt_count = 8'd0;
			frame_length = 8'd0;
			bytes_left = 8'd0;
			running_sum = 8'd0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [7:0] val);
			if (idx == CFG_EXP_CMD)
				exp_cmd = val;
			else if (idx == CFG_CAPACITY)
				capacity = val;
		endfunction

		function void close_frame(status_t st, logic [7:0] plen);
			result_t r;
			r.kind = KIND_STATUS;
			r.data_byte = 8'h00;
			r.status = st;
			r.payload_length = plen;
			r.last = 1'b1;
			due_results.push_back(r);
			phase = P_DONE;
		endfunction

		// Advance the frame state by one byte; bytes after the final status are ignored.
		function void note_byte(logic [7:0] b, logic rs);
			logic [7:0] resp;
			result_t r;
			resp = exp_cmd + 8'd1;
			if (rs)
				clear_frame();
			case (phase)
				P_HUNT: begin
					if (hunt_count < 8'd255)
						hunt_count++;
					if (b == BYTE_ZERO) begin
						start_match = (start_match < 2) ? start_match + 2'd1 : 2'd2;
					end else if (b == BYTE_START && start_match == 2) begin
						start_match = 2'd0;
						phase = P_LEN;
						return;
					end else begin
						start_match = 2'd0;
					end
					if (hunt_count >= HUNT_LIMIT)
						close_frame(ST_INVALID, 8'd0);
				end
				P_LEN: begin
					frame_length = b;
					phase = P_LCS;
				end
				P_LCS: begin
					if (frame_length + b != 8'd0 || frame_length < LEN_OVERHEAD)
						close_frame(ST_INVALID, 8'd0);
					else
						phase = P_TFI;
				end
				P_TFI: begin
					if (b != BYTE_TFI)
						close_frame(ST_INVALID, 8'd0);
					else
						phase = P_CMD;
				end
				P_CMD: begin
					if (b != resp) begin
						close_frame(ST_INVALID, 8'd0);
					end else begin
						bytes_left = frame_length - LEN_OVERHEAD;
						if (bytes_left > capacity) begin
							close_frame(ST_NOSPACE, 8'd0);
						end else begin
							running_sum = BYTE_TFI + resp;
							phase = (bytes_left == 0) ? P_DCS : P_DATA;
						end
					end
				end
				P_DATA: begin
					running_sum = running_sum + b;
					bytes_left = bytes_left - 8'd1;
					if (bytes_left == 0)
						phase = P_DCS;
					r.kind = KIND_DATA;
					r.data_byte = b;
					r.status = ST_OK;
					r.payload_length = 8'd0;
					r.last = 1'b0;
					due_results.push_back(r);
				end
				P_DCS: begin
					if (running_sum + b != 8'd0)
						close_frame(ST_INVALID, 8'd0);
					else
						close_frame(ST_OK, frame_length - LEN_OVERHEAD);
				end
				default: ;
			endcase
		endfunction

		task report(string msg);
			$display("%0t mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_result(logic k, logic [7:0] d, logic [1:0] s, logic [7:0] pl, logic l);
			result_t want;
			if (due_results.size() == 0) begin
				report($sformatf("unexpected transfer kind=%0d data=%02h status=%0d len=%0d",
					k, d, s, pl));
				return;
			end
			want = due_results.pop_front();
			if (k !== want.kind)
				report($sformatf("kind %0d, want %0d", k, want.kind));
			if (d !== want.data_byte)
				report($sformatf("data_byte %02h, want %02h", d, want.data_byte));
			if (s !== want.status)
				report($sformatf("status %0d, want %0d", s, want.status));
			if (pl !== want.payload_length)
				report($sformatf("payload_length %0d, want %0d", pl, want.payload_length));
			if (l !== want.last)
				report($sformatf("last %0d, want %0d", l, want.last));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [7:0] rx_byte;
	logic restart;
	logic out_valid;
	logic out_ready;
	logic kind;
	logic [7:0] data_byte;
	logic [1:0] status;
	logic [7:0] payload_length;
	logic last;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	deframe_checker sb = new();
	int sent_bytes = 0;
	int in_gap_max = 0;
	int out_gap_max = 0;
	int out_stall = 0;

	nfc_host_frame_deframer_core #(
		.HUNT_LIMIT(HUNT_LIMIT)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.restart(restart),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.data_byte(data_byte),
		.status(status),
		.payload_length(payload_length),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		out_ready = 1'b0;
	end

	// Hold off the receiver after each transfer for a stall drawn at random up to out_gap_max.
	always @(negedge clk) begin
		if (out_stall > 0) begin
			out_ready <= 1'b0;
			out_stall--;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_result(kind, data_byte, status, payload_length, last);
			out_stall = $urandom_range(0, out_gap_max);
		end
	end

	task automatic send_byte(logic [7:0] b, logic rs);
		int gap;
		gap = $urandom_range(0, in_gap_max);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		rx_byte <= b;
		restart <= rs;
		do @(posedge clk); while (!in_ready);
		sb.note_byte(b, rs);
		sent_bytes++;
	endtask

	// Drop valid and wait out every owed transfer, then a settling margin.
	task automatic drain_results();
		int guard;
		guard = 0;
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.due_results.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_config(logic [7:0] cmd, logic [7:0] cap);
		drain_results();
		write_reg(CFG_EXP_CMD, cmd);
		write_reg(CFG_CAPACITY, cap);
	endtask

	task automatic pick_pacing();
		in_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
		out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
	endtask

	// Build one response frame, optionally damaged, and transfer it byte by byte.
	task automatic send_frame(int plen, frame_flaw_t flaw, int extra_zeros, int junk,
			bit extreme_data);
		logic [7:0] seq[$];
		logic [7:0] len_b;
		logic [7:0] resp;
		logic [7:0] sum;
		logic [7:0] v;
		int cut;
		resp = sb.exp_cmd + 8'd1;
		repeat (junk) seq.push_back(8'($urandom_range(1, 254)));
		repeat (2 + extra_zeros) seq.push_back(BYTE_ZERO);
		seq.push_back(BYTE_START);
		len_b = (flaw == F_SHORT_LEN) ? plen[7:0] : plen[7:0] + LEN_OVERHEAD;
		seq.push_back(len_b);
		v = 8'd0 - len_b;
		if (flaw == F_LCS)
			v = v ^ 8'($urandom_range(1, 255));
		seq.push_back(v);
		v = BYTE_TFI;
		if (flaw == F_TFI)
			v = v ^ 8'($urandom_range(1, 255));
		seq.push_back(v);
		v = resp;
		if (flaw == F_CMD)
			v = v ^ 8'($urandom_range(1, 255));
		seq.push_back(v);
		sum = BYTE_TFI + resp;
		for (int i = 0; i < plen; i++) begin
			if (extreme_data)
				v = (i % 2) ? 8'hFF : 8'h00;
			else
				v = 8'($urandom_range(0, 255));
			sum = sum + v;
			seq.push_back(v);
		end
		v = 8'd0 - sum;
		if (flaw == F_DCS)
			v = v ^ 8'($urandom_range(1, 255));
		seq.push_back(v);
		seq.push_back(BYTE_ZERO);
		if (flaw == F_CUT) begin
			cut = $urandom_range(1, seq.size() - 1);
			seq = seq[0:cut - 1];
		end
		foreach (seq[i])
			send_byte(seq[i], i == 0);
	endtask

	// Random bytes, zero-heavy, with occasional restarts mid-stream.
	task automatic send_noise(int n);
		logic [7:0] v;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) == 0)
				v = BYTE_ZERO;
			else
				v = 8'($urandom_range(0, 255));
			send_byte(v, (i == 0) || ($urandom_range(0, 15) == 0));
		end
	endtask

	function automatic int pick_len();
		if ($urandom_range(0, 99) < 4)
			return $urandom_range(0, 253);
		return $urandom_range(0, 12);
	endfunction

	task automatic run_random(int quota);
		int target;
		int r;
		int junk;
		target = sent_bytes + quota;
		while (sent_bytes < target) begin
			pick_pacing();
			r = $urandom_range(0, 99);
			junk = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
			if (r < 65)
				send_frame(pick_len(), F_NONE, $urandom_range(0, 3), junk, 0);
			else if (r < 85)
				send_frame(pick_len(), frame_flaw_t'($urandom_range(F_LCS, F_CUT)),
					$urandom_range(0, 3), junk, 0);
			else
				send_noise($urandom_range(1, 70));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		restart = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_EXP_CMD;
		cfg_data = 8'h00;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// directed frames covering the special cases
		set_config(8'h4A, 8'd3);
		send_frame(0, F_NONE, 0, 0, 0);
		send_frame(2, F_NONE, 2, 0, 1);
		send_frame(1, F_LCS, 0, 0, 0);
		send_frame(0, F_SHORT_LEN, 0, 0, 0);
		send_frame(1, F_SHORT_LEN, 0, 0, 0);
		send_frame(1, F_TFI, 0, 0, 0);
		send_frame(1, F_CMD, 0, 0, 0);
		send_frame(4, F_NONE, 0, 0, 0);
		send_frame(3, F_DCS, 0, 0, 0);
		for (int i = 0; i < HUNT_LIMIT + 2; i++)
			send_byte(8'($urandom_range(1, 254)), i == 0);

		pick_pacing();
		set_config(8'hFF, 8'h00);
		run_random(240);
		set_config(8'h00, 8'hFF);
		run_random(240);
		set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 15)));
		run_random(240);
		set_config(8'($urandom_range(0, 255)), 8'd253);
		run_random(240);
		set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		run_random(240);

		drain_results();
		if (sb.due_results.size() != 0)
			sb.report($sformatf("%0d expected transfers never arrived",
				sb.due_results.size()));
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

### filelist.f
sv/nfcd_pkg.sv
sv/nfcd_front.sv
sv/nfcd_queue.sv
sv/nfcd_back.sv
sv/nfcd_core_top.sv
sim/testbench.sv
